FILE: rtl/sqvs_pkg.sv
// Shared types and constants for the rotated sprite quad vertex setup.
// Used by every module of the block; depends on nothing.
package sqvs_pkg;

	localparam int SINE_ENTRIES_DEF = 1024;
	localparam int SCR_W_BITS = 13;
	localparam int TEX_W_BITS = 14;
	localparam int CFG_DATA_BITS = 14;
	localparam int MQ_DEPTH = 4;
	localparam int OUT_DEPTH = 32;
	localparam int DIV_NUM_BITS = 36;
	localparam int DIV_DEN_BITS = 17;
	localparam int DIV_Q_BITS = 16;
	localparam int DIV_STAGES = DIV_Q_BITS;

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// numerator offsets that move each quotient into [0, 65535]
	localparam logic [35:0] NX_OFF_MUL = 36'd262152;
	localparam logic [35:0] NY_OFF_MUL = 36'd262136;
	localparam logic [35:0] TEX_OFF_MUL = 36'd65537;

	localparam logic [SCR_W_BITS-1:0] SCR_W_RST = 13'd1920;
	localparam logic [SCR_W_BITS-1:0] SCR_H_RST = 13'd1080;
	localparam logic [TEX_W_BITS-1:0] TEX_W_RST = 14'd8;
	localparam logic [TEX_W_BITS-1:0] TEX_H_RST = 14'd8;

	typedef enum logic [1:0] {
		REG_SCR_W,
		REG_SCR_H,
		REG_TEX_W,
		REG_TEX_H
	} reg_idx_t;

	typedef struct packed {
		logic [SCR_W_BITS-1:0] scr_w;
		logic [SCR_W_BITS-1:0] scr_h;
		logic [TEX_W_BITS-1:0] tex_w;
		logic [TEX_W_BITS-1:0] tex_h;
	} cfg_t;

	typedef struct packed {
		logic signed [17:0] cx;
		logic signed [17:0] cy;
		logic signed [15:0] dw;
		logic signed [15:0] dh;
		logic signed [13:0] sx;
		logic signed [13:0] sy;
		logic signed [13:0] sw;
		logic signed [13:0] sh;
		logic [31:0] color;
		logic sin_neg;
		logic cos_neg;
	} rec_t;

endpackage

FILE: rtl/sqvs_front.sv
// Front end: takes sprite requests, forms rectangle centres and resolves the
// angle into sine/cosine table addresses and signs. Depends on sqvs_pkg.
module sqvs_front import sqvs_pkg::*; #(
	parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF,
	localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [15:0] dst_x,
	input  logic signed [15:0] dst_y,
	input  logic signed [15:0] dst_w,
	input  logic signed [15:0] dst_h,
	input  logic signed [13:0] src_x,
	input  logic signed [13:0] src_y,
	input  logic signed [13:0] src_w,
	input  logic signed [13:0] src_h,
	input  logic [15:0] angle,
	input  logic [31:0] color_rgba,
	output logic out_valid,
	input  logic out_ready,
	output rec_t out_rec,
	output logic [IW-1:0] out_idx_s,
	output logic [IW-1:0] out_idx_c
);

	localparam int KW = $clog2(SINE_TABLE_ENTRIES);
	localparam int MW = KW + 2;
	localparam logic [MW-1:0] N1 = MW'(SINE_TABLE_ENTRIES);
	localparam logic [MW-1:0] N2 = MW'(2 * SINE_TABLE_ENTRIES);
	localparam logic [MW-1:0] N3 = MW'(3 * SINE_TABLE_ENTRIES);
	localparam logic [IW-1:0] NI = IW'(SINE_TABLE_ENTRIES);

	logic v_s1, v_s2, en1, en2;
	rec_t rec_s1, rec_s2, rec_n;
	logic [KW-1:0] k_s1;
	logic [IW-1:0] idx_s_s2, idx_c_s2;
	logic [KW+16:0] prod;
	logic [MW-1:0] m, r;
	logic [1:0] q;
	logic [IW-1:0] ri, nmr;

	assign en2 = !v_s2 || out_ready;
	assign en1 = !v_s1 || en2;
	assign full = !en1;

	assign prod = (KW + 17)'(angle) * (KW + 17)'(SINE_TABLE_ENTRIES);

	always_comb begin
		m = {k_s1, 2'b00};
		if (m >= N3) begin
			q = 2'd3;
			r = m - N3;
		end else if (m >= N2) begin
			q = 2'd2;
			r = m - N2;
		end else if (m >= N1) begin
			q = 2'd1;
			r = m - N1;
		end else begin
			q = 2'd0;
			r = m;
		end
		ri = IW'(r);
		nmr = NI - ri;
		rec_n = rec_s1;
		rec_n.sin_neg = q[1];
		rec_n.cos_neg = (q == 2'd1) || (q == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= push;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && push) begin
			rec_s1.cx <= (18'(dst_x) <<< 1) + 18'(dst_w);
			rec_s1.cy <= (18'(dst_y) <<< 1) + 18'(dst_h);
			rec_s1.dw <= dst_w;
			rec_s1.dh <= dst_h;
			rec_s1.sx <= src_x;
			rec_s1.sy <= src_y;
			rec_s1.sw <= src_w;
			rec_s1.sh <= src_h;
			rec_s1.color <= color_rgba;
			rec_s1.sin_neg <= 1'b0;
			rec_s1.cos_neg <= 1'b0;
			k_s1 <= prod[KW+15:16];
		end
		if (en2 && v_s1) begin
			rec_s2 <= rec_n;
			idx_s_s2 <= q[0] ? nmr : ri;
			idx_c_s2 <= q[0] ? ri : nmr;
		end
	end

	assign out_valid = v_s2;
	assign out_rec = rec_s2;
	assign out_idx_s = idx_s_s2;
	assign out_idx_c = idx_c_s2;

endmodule

FILE: rtl/sqvs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with the quotient
// clamped to its unsigned range. Depends on sqvs_pkg for default widths.
module sqvs_div import sqvs_pkg::*; #(
	parameter int NW = DIV_NUM_BITS,
	parameter int DW = DIV_DEN_BITS,
	parameter int QW = DIV_Q_BITS
) (
	input  logic clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int RW = DW + QW;

	logic [RW-1:0] rem_in [0:QW-1];
	logic [QW-1:0] quo_in [0:QW-1];
	logic lo_in [0:QW-1];
	logic hi_in [0:QW-1];
	logic [RW-1:0] rem_s [0:QW-1];
	logic [QW-1:0] quo_s [0:QW-1];
	logic lo_s [0:QW-1];
	logic hi_s [0:QW-1];

	assign rem_in[0] = num[RW-1:0];
	assign quo_in[0] = '0;
	assign lo_in[0] = num[NW-1];
	assign hi_in[0] = !num[NW-1] && (num[NW-2:0] >= (NW - 1)'({den, {QW{1'b0}}}));

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int B = QW - 1 - j;
		logic [RW-1:0] dsh;
		logic ge;

		if (j > 0) begin : g_link
			assign rem_in[j] = rem_s[j-1];
			assign quo_in[j] = quo_s[j-1];
			assign lo_in[j] = lo_s[j-1];
			assign hi_in[j] = hi_s[j-1];
		end

		assign dsh = RW'(den) << B;
		assign ge = rem_in[j] >= dsh;

		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? rem_in[j] - dsh : rem_in[j];
			quo_s[j] <= quo_in[j] | (QW'(ge) << B);
			lo_s[j] <= lo_in[j];
			hi_s[j] <= hi_in[j];
		end
	end

	assign quo = lo_s[QW-1] ? '0 : (hi_s[QW-1] ? '1 : quo_s[QW-1]);

endmodule

FILE: rtl/sqvs_back.sv
// Back end: sine ROM, corner sequencer, rotation, coordinate dividers and the
// result queue. Depends on sqvs_pkg and sqvs_div.
module sqvs_back import sqvs_pkg::*; #(
	parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF,
	localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_take,
	input  rec_t in_rec,
	input  logic [IW-1:0] in_idx_s,
	input  logic [IW-1:0] in_idx_c,
	output logic empty,
	input  logic pop,
	output logic [1:0] vertex_index,
	output logic signed [15:0] ndc_x,
	output logic signed [15:0] ndc_y,
	output logic signed [15:0] tex_u,
	output logic signed [15:0] tex_v,
	output logic [31:0] color_out,
	output logic last
);

	localparam int LAT = DIV_STAGES + 2;
	localparam int PW = $clog2(OUT_DEPTH) + 1;
	localparam int OW = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [1:0] corner;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] u;
		logic [15:0] v;
		logic [31:0] color;
	} vtx_t;

	logic [14:0] rom [0:SINE_TABLE_ENTRIES];

	for (genvar r = 0; r <= SINE_TABLE_ENTRIES; r++) begin : g_rom
		localparam logic [63:0] X = 64'(r) * HALF_PI_Q30 / SINE_TABLE_ENTRIES;
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = Q30_ONE - X2 / 72;
		localparam logic [63:0] T2 = Q30_ONE - ((X2 * T1) >> 30) / 42;
		localparam logic [63:0] T3 = Q30_ONE - ((X2 * T2) >> 30) / 20;
		localparam logic [63:0] T4 = Q30_ONE - ((X2 * T3) >> 30) / 6;
		localparam logic [63:0] SV = (X * T4) >> 30;
		localparam logic [63:0] V = (SV + 64'd32768) >> 16;
		assign rom[r] = V[14:0];
	end

	// corner sequencer
	logic act_q, issue, ld;
	logic [1:0] cnt_q;
	logic [OW-1:0] occ_q;
	rec_t spr_q;
	logic [14:0] sin_rom_q, cos_rom_q;
	logic signed [15:0] sn, cs;
	logic signed [16:0] rx, ry;
	logic [PW-1:0] wp_q, rp_q, fcnt;
	logic fifo_push, fifo_pop;

	assign issue = act_q && (occ_q < OW'(OUT_DEPTH));
	assign ld = in_valid && (!act_q || (issue && cnt_q == 2'd3));
	assign in_take = ld;
	assign fcnt = wp_q - rp_q;
	assign empty = (fcnt == '0);
	assign fifo_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= 2'd0;
			occ_q <= '0;
		end else begin
			if (ld)
				act_q <= 1'b1;
			else if (issue && cnt_q == 2'd3)
				act_q <= 1'b0;
			if (issue)
				cnt_q <= cnt_q + 2'd1;
			occ_q <= occ_q + OW'(issue) - OW'(fifo_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			spr_q <= in_rec;
			sin_rom_q <= rom[in_idx_s];
			cos_rom_q <= rom[in_idx_c];
		end
	end

	assign sn = spr_q.sin_neg ? -$signed({1'b0, sin_rom_q}) : $signed({1'b0, sin_rom_q});
	assign cs = spr_q.cos_neg ? -$signed({1'b0, cos_rom_q}) : $signed({1'b0, cos_rom_q});
	assign rx = cnt_q[0] ? 17'(spr_q.dw) : -17'(spr_q.dw);
	assign ry = cnt_q[1] ? 17'(spr_q.dh) : -17'(spr_q.dh);

	// rotation products
	logic signed [32:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [17:0] cx_s1, cy_s1;
	logic signed [14:0] tu_s1, tv_s1;

	always_ff @(posedge clk) begin
		pa_s1 <= 33'(cs) * 33'(rx);
		pb_s1 <= 33'(sn) * 33'(ry);
		pc_s1 <= 33'(sn) * 33'(rx);
		pd_s1 <= 33'(cs) * 33'(ry);
		cx_s1 <= spr_q.cx;
		cy_s1 <= spr_q.cy;
		tu_s1 <= 15'(spr_q.sx) + (cnt_q[0] ? 15'(spr_q.sw) : 15'sd0);
		tv_s1 <= 15'(spr_q.sy) + (cnt_q[1] ? 15'(spr_q.sh) : 15'sd0);
	end

	// divider numerators and denominators
	logic [SCR_W_BITS-1:0] scr_w, scr_h;
	logic [TEX_W_BITS-1:0] tex_w, tex_h;
	logic signed [35:0] off_x, off_y, off_u, off_v;
	logic signed [35:0] nx_num_s2, ny_num_s2, u_num_s2, v_num_s2;
	logic [DIV_DEN_BITS-1:0] den_x, den_y, den_u, den_v;
	logic [15:0] tx, ty, tu, tv;

	assign scr_w = (cfg.scr_w == '0) ? SCR_W_BITS'(1) : cfg.scr_w;
	assign scr_h = (cfg.scr_h == '0) ? SCR_W_BITS'(1) : cfg.scr_h;
	assign tex_w = (cfg.tex_w == '0) ? TEX_W_BITS'(1) : cfg.tex_w;
	assign tex_h = (cfg.tex_h == '0) ? TEX_W_BITS'(1) : cfg.tex_h;
	assign off_x = $signed(36'(scr_w) * NX_OFF_MUL);
	assign off_y = $signed(36'(scr_h) * NY_OFF_MUL);
	assign off_u = $signed(36'(tex_w) * TEX_OFF_MUL);
	assign off_v = $signed(36'(tex_h) * TEX_OFF_MUL);
	assign den_x = {scr_w, 4'b0000};
	assign den_y = {scr_h, 4'b0000};
	assign den_u = {2'b00, tex_w, 1'b0};
	assign den_v = {2'b00, tex_h, 1'b0};

	always_ff @(posedge clk) begin
		nx_num_s2 <= (36'(cx_s1) <<< 14) + 36'(pa_s1) - 36'(pb_s1) + off_x;
		ny_num_s2 <= (36'(cy_s1) <<< 14) + 36'(pc_s1) + 36'(pd_s1) + off_y;
		u_num_s2 <= (36'(tu_s1) <<< 15) + off_u;
		v_num_s2 <= (36'(tv_s1) <<< 15) + off_v;
	end

	sqvs_div u_div_x (.clk(clk), .num(nx_num_s2), .den(den_x), .quo(tx));
	sqvs_div u_div_y (.clk(clk), .num(ny_num_s2), .den(den_y), .quo(ty));
	sqvs_div u_div_u (.clk(clk), .num(u_num_s2), .den(den_u), .quo(tu));
	sqvs_div u_div_v (.clk(clk), .num(v_num_s2), .den(den_v), .quo(tv));

	// side line alongside the arithmetic
	logic vld_s [0:LAT-1];
	logic [1:0] cor_s [0:LAT-1];
	logic [31:0] col_s [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= issue;
			for (int i = 1; i < LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		cor_s[0] <= cnt_q;
		col_s[0] <= spr_q.color;
		for (int i = 1; i < LAT; i++) begin
			cor_s[i] <= cor_s[i-1];
			col_s[i] <= col_s[i-1];
		end
	end

	// result queue
	vtx_t fifo_q [0:OUT_DEPTH-1];
	vtx_t wr_vtx, rd_vtx;

	assign fifo_push = vld_s[LAT-1];
	assign wr_vtx.corner = cor_s[LAT-1];
	assign wr_vtx.nx = tx ^ 16'h8000;
	assign wr_vtx.ny = ~ty ^ 16'h8000;
	assign wr_vtx.u = tu ^ 16'h8000;
	assign wr_vtx.v = tv ^ 16'h8000;
	assign wr_vtx.color = col_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (fifo_push)
				wp_q <= wp_q + PW'(1);
			if (fifo_pop)
				rp_q <= rp_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_push)
			fifo_q[wp_q[PW-2:0]] <= wr_vtx;
	end

	assign rd_vtx = fifo_q[rp_q[PW-2:0]];
	assign vertex_index = rd_vtx.corner;
	assign ndc_x = rd_vtx.nx;
	assign ndc_y = rd_vtx.ny;
	assign tex_u = rd_vtx.u;
	assign tex_v = rd_vtx.v;
	assign color_out = rd_vtx.color;
	assign last = (rd_vtx.corner == 2'd3);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(OUT_DEPTH) && OW'(fcnt) <= occ_q)
		else $error("result credit count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> fcnt != PW'(OUT_DEPTH))
		else $error("result queue written while full");
	a_load_active: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> act_q)
		else $error("sprite load did not start a corner run");
	a_cnt_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> act_q)
		else $error("corner count moved without a sprite");

endmodule

FILE: rtl/sprite_quad_vertex_setup.sv
// Rotated sprite quad vertex setup. Each sprite request yields four vertices
// (top-left, top-right, bottom-left, bottom-right) on the result queue, one
// vertex per cycle while the result queue has room, so a new sprite is taken
// as the last vertex of the previous one issues; the single vertex output sets
// that rate. A pushed sprite passes two front stages, the sprite queue, a sine
// ROM read, two rotation stages and a 16-stage divider per coordinate.
// Size registers are only to be written while no sprite is in flight.
// Depends on sqvs_pkg, sqvs_front, sqvs_back.
module sprite_quad_vertex_setup import sqvs_pkg::*; #(
	parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF,
	localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [15:0] dst_x,
	input  logic signed [15:0] dst_y,
	input  logic signed [15:0] dst_w,
	input  logic signed [15:0] dst_h,
	input  logic signed [13:0] src_x,
	input  logic signed [13:0] src_y,
	input  logic signed [13:0] src_w,
	input  logic signed [13:0] src_h,
	input  logic [15:0] angle,
	input  logic [31:0] color_rgba,
	output logic empty,
	input  logic pop,
	output logic [1:0] vertex_index,
	output logic signed [15:0] ndc_x,
	output logic signed [15:0] ndc_y,
	output logic signed [15:0] tex_u,
	output logic signed [15:0] tex_v,
	output logic [31:0] color_out,
	output logic last,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	localparam int MP = $clog2(MQ_DEPTH) + 1;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scr_w <= SCR_W_RST;
			cfg_q.scr_h <= SCR_H_RST;
			cfg_q.tex_w <= TEX_W_RST;
			cfg_q.tex_h <= TEX_H_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_SCR_W: cfg_q.scr_w <= cfg_wdata[SCR_W_BITS-1:0];
				REG_SCR_H: cfg_q.scr_h <= cfg_wdata[SCR_W_BITS-1:0];
				REG_TEX_W: cfg_q.tex_w <= cfg_wdata[TEX_W_BITS-1:0];
				REG_TEX_H: cfg_q.tex_h <= cfg_wdata[TEX_W_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic f_valid, f_ready, b_take;
	rec_t f_rec;
	logic [IW-1:0] f_idx_s, f_idx_c;

	sqvs_front #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.dst_x(dst_x), .dst_y(dst_y), .dst_w(dst_w), .dst_h(dst_h),
		.src_x(src_x), .src_y(src_y), .src_w(src_w), .src_h(src_h),
		.angle(angle), .color_rgba(color_rgba),
		.out_valid(f_valid), .out_ready(f_ready), .out_rec(f_rec),
		.out_idx_s(f_idx_s), .out_idx_c(f_idx_c)
	);

	// sprite queue between front and back
	rec_t mq_rec_q [0:MQ_DEPTH-1];
	logic [IW-1:0] mq_is_q [0:MQ_DEPTH-1];
	logic [IW-1:0] mq_ic_q [0:MQ_DEPTH-1];
	logic [MP-1:0] mq_wp_q, mq_rp_q, mq_cnt;
	logic mq_nonempty;

	assign mq_cnt = mq_wp_q - mq_rp_q;
	assign f_ready = (mq_cnt != MP'(MQ_DEPTH));
	assign mq_nonempty = (mq_cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_wp_q <= '0;
			mq_rp_q <= '0;
		end else begin
			if (f_valid && f_ready)
				mq_wp_q <= mq_wp_q + MP'(1);
			if (b_take)
				mq_rp_q <= mq_rp_q + MP'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (f_valid && f_ready) begin
			mq_rec_q[mq_wp_q[MP-2:0]] <= f_rec;
			mq_is_q[mq_wp_q[MP-2:0]] <= f_idx_s;
			mq_ic_q[mq_wp_q[MP-2:0]] <= f_idx_c;
		end
	end

	sqvs_back #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(mq_nonempty), .in_take(b_take),
		.in_rec(mq_rec_q[mq_rp_q[MP-2:0]]),
		.in_idx_s(mq_is_q[mq_rp_q[MP-2:0]]),
		.in_idx_c(mq_ic_q[mq_rp_q[MP-2:0]]),
		.empty(empty), .pop(pop), .vertex_index(vertex_index),
		.ndc_x(ndc_x), .ndc_y(ndc_y), .tex_u(tex_u), .tex_v(tex_v),
		.color_out(color_out), .last(last)
	);

endmodule

FILE: test/tb_sprite_quad_vertex_setup.sv
// Testbench for sprite_quad_vertex_setup: drives sprite requests through the
// push/full queue, pops vertices and checks each against a local predictor or typed table values.
// Depends on sqvs_pkg and the sprite_quad_vertex_setup RTL only.
`timescale 1ns / 100ps

module tb_sprite_quad_vertex_setup import sqvs_pkg::*;;

	typedef struct {
		logic signed [15:0] dst_x, dst_y, dst_w, dst_h;
		logic signed [13:0] src_x, src_y, src_w, src_h;
		logic [15:0] angle;
		logic [31:0] color;
	} sprite_t;

	typedef struct {
		logic [1:0] idx;
		logic signed [15:0] nx, ny, u, v;
		logic [31:0] col;
		logic lst;
	} vertex_t;

	typedef struct {
		sprite_t s;
		bit typed;
		logic signed [15:0] nx, ny, u, v;
	} dir_row_t;

	localparam int N_DIR = 16;

	logic clk = 0, arst_n = 0;
	logic push = 0, pop = 0;
	logic full, empty;
	logic signed [15:0] dst_x = 0, dst_y = 0, dst_w = 0, dst_h = 0;
	logic signed [13:0] src_x = 0, src_y = 0, src_w = 0, src_h = 0;
	logic [15:0] angle = 0;
	logic [31:0] color_rgba = 0;
	logic [1:0] vertex_index;
	logic signed [15:0] ndc_x, ndc_y, tex_u, tex_v;
	logic [31:0] color_out;
	logic last;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = REG_SCR_W;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = 0;

	logic [SCR_W_BITS-1:0] scr_w = SCR_W_RST, scr_h = SCR_H_RST;
	logic [TEX_W_BITS-1:0] tex_w = TEX_W_RST, tex_h = TEX_H_RST;

	vertex_t vert_q[$];
	int fail_cnt = 0;
	bit fast = 0;
	bit hold_req = 0;

	sprite_quad_vertex_setup dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q -= 1;
		return q;
	endfunction

	function automatic logic signed [15:0] sat16(longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// sine of m quarter-steps, Q1.14, Taylor series in Q30
	function automatic longint sine_q14(longint unsigned m);
		longint unsigned n, q, r, x, x2, t, s, v;
		n = SINE_ENTRIES_DEF;
		m = m % (4 * n);
		q = m / n;
		r = m % n;
		if (q[0])
			r = n - r;
		x = r * HALF_PI_Q30 / n;
		x2 = (x * x) >> 30;
		t = Q30_ONE - x2 / 72;
		t = Q30_ONE - ((x2 * t) >> 30) / 42;
		t = Q30_ONE - ((x2 * t) >> 30) / 20;
		t = Q30_ONE - ((x2 * t) >> 30) / 6;
		s = (x * t) >> 30;
		v = (s + 32768) >> 16;
		return (q >= 2) ? -longint'(v) : longint'(v);
	endfunction

	task automatic predict_corners(sprite_t s);
		longint unsigned k;
		longint sn, cs, sw, sh, tw, th, cx, cy, rx, ry, px, py, tu, tv;
		vertex_t e;
		k = (longint'(s.angle) * SINE_ENTRIES_DEF) >> 16;
		sn = sine_q14(4 * k);
		cs = sine_q14(4 * k + SINE_ENTRIES_DEF);
		sw = (scr_w == 0) ? 1 : scr_w;
		sh = (scr_h == 0) ? 1 : scr_h;
		tw = (tex_w == 0) ? 1 : tex_w;
		th = (tex_h == 0) ? 1 : tex_h;
		cx = (2 * longint'(s.dst_x) + s.dst_w) * 16384;
		cy = (2 * longint'(s.dst_y) + s.dst_h) * 16384;
		for (int i = 0; i < 4; i++) begin
			rx = i[0] ? longint'(s.dst_w) : -longint'(s.dst_w);
			ry = i[1] ? longint'(s.dst_h) : -longint'(s.dst_h);
			px = cx + cs * rx - sn * ry;
			py = cy + sn * rx + cs * ry;
			tu = longint'(s.src_x) + (i[0] ? longint'(s.src_w) : 0);
			tv = longint'(s.src_y) + (i[1] ? longint'(s.src_h) : 0);
			e.idx = 2'(i);
			e.nx = sat16(floor_div(px + 8 * sw, 16 * sw) - 16384);
			e.ny = sat16(16384 - floor_div(py + 8 * sh, 16 * sh));
			e.u = sat16(floor_div(2 * tu * 16384 + tw, 2 * tw));
			e.v = sat16(floor_div(2 * tv * 16384 + th, 2 * th));
			e.col = s.color;
			e.lst = (i == 3);
			vert_q.push_back(e);
		end
	endtask

	function automatic sprite_t rand_sprite();
		sprite_t s;
		if ($urandom_range(0, 9) < 2) begin
			s.dst_x = 16'($urandom); s.dst_y = 16'($urandom);
			s.dst_w = 16'($urandom); s.dst_h = 16'($urandom);
			s.src_x = 14'($urandom); s.src_y = 14'($urandom);
			s.src_w = 14'($urandom); s.src_h = 14'($urandom);
		end else begin
			s.dst_x = 16'(int'($urandom_range(0, 8191)) - 4096);
			s.dst_y = 16'(int'($urandom_range(0, 8191)) - 4096);
			s.dst_w = 16'(int'($urandom_range(0, 4095)) - 2048);
			s.dst_h = 16'(int'($urandom_range(0, 4095)) - 2048);
			s.src_x = 14'($urandom_range(0, 255));
			s.src_y = 14'($urandom_range(0, 255));
			s.src_w = 14'(int'($urandom_range(0, 127)) - 64);
			s.src_h = 14'(int'($urandom_range(0, 127)) - 64);
		end
		s.angle = 16'($urandom);
		s.color = $urandom;
		return s;
	endfunction

	// request is taken at the first edge with push high and full low
	task automatic send_sprite(sprite_t s, int gap);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		dst_x <= s.dst_x; dst_y <= s.dst_y; dst_w <= s.dst_w; dst_h <= s.dst_h;
		src_x <= s.src_x; src_y <= s.src_y; src_w <= s.src_w; src_h <= s.src_h;
		angle <= s.angle;
		color_rgba <= s.color;
		do @(posedge clk); while (full);
	endtask

	function automatic int draw_gap();
		return fast ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic wait_idle();
		push <= 0;
		while (vert_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_BITS'(val);
		case (idx)
			REG_SCR_W: scr_w = SCR_W_BITS'(val);
			REG_SCR_H: scr_h = SCR_W_BITS'(val);
			REG_TEX_W: tex_w = TEX_W_BITS'(val);
			REG_TEX_H: tex_h = TEX_W_BITS'(val);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_sizes(int sw, int sh, int tw, int th);
		write_reg(REG_SCR_W, sw);
		write_reg(REG_SCR_H, sh);
		write_reg(REG_TEX_W, tw);
		write_reg(REG_TEX_H, th);
	endtask

	task automatic run_random(int count);
		sprite_t s;
		for (int i = 0; i < count; i++) begin
			s = rand_sprite();
			send_sprite(s, draw_gap());
			predict_corners(s);
		end
	endtask

	// vertex consumer
	initial begin
		vertex_t e;
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				pop <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end else begin
				stall = draw_gap();
				if (stall > 0) begin
					pop <= 0;
					repeat (stall) @(posedge clk);
				end
			end
			pop <= 1;
			do @(posedge clk); while (empty);
			if (vert_q.size() == 0) begin
				$display("%0t: unexpected vertex idx=%0d", $time, vertex_index);
				fail_cnt++;
			end else begin
				e = vert_q.pop_front();
				if (vertex_index !== e.idx) begin
					$display("%0t: vertex_index exp %0d got %0d", $time, e.idx, vertex_index);
					fail_cnt++;
				end
				if (ndc_x !== e.nx) begin
					$display("%0t: ndc_x exp %0d got %0d", $time, e.nx, ndc_x);
					fail_cnt++;
				end
				if (ndc_y !== e.ny) begin
					$display("%0t: ndc_y exp %0d got %0d", $time, e.ny, ndc_y);
					fail_cnt++;
				end
				if (tex_u !== e.u) begin
					$display("%0t: tex_u exp %0d got %0d", $time, e.u, tex_u);
					fail_cnt++;
				end
				if (tex_v !== e.v) begin
					$display("%0t: tex_v exp %0d got %0d", $time, e.v, tex_v);
					fail_cnt++;
				end
				if (color_out !== e.col) begin
					$display("%0t: color_out exp %h got %h", $time, e.col, color_out);
					fail_cnt++;
				end
				if (last !== e.lst) begin
					$display("%0t: last exp %b got %b", $time, e.lst, last);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		dir_row_t dir_tab[N_DIR];
		vertex_t e;
		dir_tab = '{
			'{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, -16384, 16384, 0, 0},
			'{'{0, 0, 0, 0, 8191, -8192, 0, 0, 0, 32'hFFFF_FFFF}, 1,
				-16384, 16384, 32767, -32768},
			'{'{0, 0, 0, 0, -8192, 8191, 0, 0, 16'hFFFF, 32'h1234_5678}, 1,
				-16384, 16384, -32768, 32767},
			'{'{1600, 800, 3200, 1600, 0, 0, 8, 8, 0, 32'hFF00_00FF}, 0, 0, 0, 0, 0},
			'{'{1600, 800, 3200, 1600, 0, 0, 8, 8, 16384, 32'h00FF_00FF}, 0, 0, 0, 0, 0},
			'{'{1600, 800, 3200, 1600, 0, 0, 8, 8, 32768, 32'h0000_FFFF}, 0, 0, 0, 0, 0},
			'{'{1600, 800, 3200, 1600, 0, 0, 8, 8, 49152, 32'h8080_8080}, 0, 0, 0, 0, 0},
			'{'{1600, 800, 3200, 1600, 0, 0, 8, 8, 65535, 32'h0101_0101}, 0, 0, 0, 0, 0},
			'{'{100, 100, 640, 320, 8, 8, -8, -8, 8192, 32'hA5A5_5A5A}, 0, 0, 0, 0, 0},
			'{'{32767, 32767, 32767, 32767, 8191, 8191, 8191, 8191, 16'hFFFF,
				32'hFFFF_FFFF}, 0, 0, 0, 0, 0},
			'{'{-32768, -32768, -32768, -32768, -8192, -8192, -8192, -8192, 16'h8000,
				0}, 0, 0, 0, 0, 0},
			'{'{-32768, 32767, 32767, -32768, 0, 0, -8192, 8191, 16'h2000,
				32'h5555_AAAA}, 0, 0, 0, 0, 0},
			'{'{0, 0, -32768, 32767, 4, 4, 2, -2, 16'h6000, 32'hAAAA_5555}, 0, 0, 0, 0, 0},
			'{'{-160, -160, 320, 320, 0, 0, 1, 1, 16'h0040, 32'h0F0F_F0F0}, 0, 0, 0, 0, 0},
			'{'{15360, 8640, 16, 16, 7, 7, 1, 1, 16'h4000, 32'hF0F0_0F0F}, 0, 0, 0, 0, 0},
			'{'{12345, -2345, -800, 1200, 3, -5, -7, 9, 16'hC123, 32'h3C3C_C3C3}, 0, 0, 0, 0, 0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_sprite(dir_tab[i].s, draw_gap());
			if (dir_tab[i].typed) begin
				for (int c = 0; c < 4; c++) begin
					e.idx = 2'(c);
					e.nx = dir_tab[i].nx;
					e.ny = dir_tab[i].ny;
					e.u = dir_tab[i].u;
					e.v = dir_tab[i].v;
					e.col = dir_tab[i].s.color;
					e.lst = (c == 3);
					vert_q.push_back(e);
				end
			end else
				predict_corners(dir_tab[i].s);
		end
		run_random(20);

		// consumer holds off while sprites keep coming back to back
		fast = 1;
		hold_req = 1;
		run_random(25);
		fast = 0;
		wait_idle();

		set_sizes(1, 1, 1, 1);
		run_random(20);
		wait_idle();
		set_sizes(4096, 4096, 8192, 8192);
		fast = 1;
		run_random(20);
		fast = 0;
		wait_idle();
		set_sizes(0, 0, 0, 0);
		run_random(15);
		wait_idle();
		set_sizes(8191, 8191, 16383, 16383);
		run_random(15);
		wait_idle();
		set_sizes($urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(1, 8192), $urandom_range(1, 8192));
		run_random(20);
		wait_idle();
		set_sizes(640, 480, 256, 256);
		fast = 1;
		run_random(15);
		fast = 0;
		wait_idle();

		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
